// ===== src/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the chunked frame reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    // Register reset values and fixed limits.
    localparam logic [15:0] C_TIMEOUT_RST  = 16'd5000;
    localparam logic [15:0] C_MAX_LEN_RST  = 16'd32768;
    localparam logic [31:0] C_MAX_FRAME    = 32'd32768;
    localparam int          C_MAX_CHUNK    = 512;
    localparam logic [16:0] C_IDLE_MAX     = 17'h1FFFF;
    localparam logic [9:0]  C_HDR_MIN      = 10'd8;
    localparam logic [7:0]  C_SYNC0        = 8'hFF;
    localparam logic [7:0]  C_SYNC1        = 8'hFE;
    localparam int          C_CMDQ_DEPTH   = 4;

    // Register index decoded from the address.
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    // Commands passed from the front to the back.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_PAIR  = 3'd2;
    localparam logic [2:0] OP_DROP  = 3'd3;
    localparam logic [2:0] OP_JUDGE = 3'd4;

    // Result kinds.
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_HEADER   = 3'd1;
    localparam logic [2:0] KIND_TOO_BIG  = 3'd2;
    localparam logic [2:0] KIND_ZERO_LEN = 3'd3;
    localparam logic [2:0] KIND_STRAY    = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic        tmo;        // idle time exceeded at chunk start
        logic        act;        // chunk start byte is data or stray
        logic [7:0]  data_byte;
        logic [31:0] length;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [14:0] offset;
        logic [7:0]  payload;
        logic        frame_done;
        logic [31:0] declared_length;
        logic        run_last;
    } t_result;

endpackage

`default_nettype wire

// ===== src/chunked_frame_reassembler_unit.sv =====
// ----------------------------------------------------------------------------
// chunked_frame_reassembler_unit
// Rebuilds frames from byte-serial notification chunks and millisecond ticks.
// ----------------------------------------------------------------------------
// The unit accepts one item (a tick or a chunk byte) per clock cycle as long
// as its four-entry command queue has room. The front tracks the chunk role,
// byte position, header length and idle time and turns each byte into a
// command; the back applies commands to the open frame and registers results.
// A result passes through the command queue and the output register. The result
// port delivers one result per cycle; an item with two results (a timeout then a
// stray report, or a held sync byte released as data with the next byte) parks
// the second in a pending register. Throughput is one item per cycle whenever
// the result side keeps up. Registers: timeout_ms at address 0, max_frame_length
// at address 4. Write them only while idle; the block does not enforce that.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_frame_reassembler_unit #(
    parameter int P_MAX_CHUNK = cfr_pkg::C_MAX_CHUNK
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Item input channel
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_chunk_start,
    input  wire logic [9:0]    i_chunk_length,
    // Result output channel
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_kind,
    output logic [14:0]        o_offset,
    output logic [7:0]         o_payload,
    output logic               o_frame_done,
    output logic [31:0]        o_declared_length,
    output logic               o_run_last,
    // Configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]      r_timeout_ms;
    logic [15:0]      r_max_frame_length;
    logic             cfg_wr;
    logic             q_full, q_push, q_valid, q_pop;
    cfr_pkg::t_cmd    push_cmd, q_cmd;
    cfr_pkg::t_result result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms       <= cfr_pkg::C_TIMEOUT_RST;
            r_max_frame_length <= cfr_pkg::C_MAX_LEN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                cfr_pkg::REG_TIMEOUT: r_timeout_ms       <= pwdata[15:0];
                cfr_pkg::REG_MAX_LEN: r_max_frame_length <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cfr_pkg::REG_TIMEOUT: prdata = {16'd0, r_timeout_ms};
            cfr_pkg::REG_MAX_LEN: prdata = {16'd0, r_max_frame_length};
        endcase
    end

    cfr_front #(
        .P_MAX_CHUNK (P_MAX_CHUNK)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_data_byte    (i_data_byte),
        .i_chunk_start  (i_chunk_start),
        .i_chunk_length (i_chunk_length),
        .i_timeout_ms   (r_timeout_ms),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (push_cmd)
    );

    cfr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    cfr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_max_frame_length (r_max_frame_length),
        .i_q_valid          (q_valid),
        .i_q_data           (q_cmd),
        .o_pop              (q_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_result           (result)
    );

    assign o_kind            = result.kind;
    assign o_offset          = result.offset;
    assign o_payload         = result.payload;
    assign o_frame_done      = result.frame_done;
    assign o_declared_length = result.declared_length;
    assign o_run_last        = result.run_last;

endmodule

`default_nettype wire

// ===== src/cfr_front.sv =====
// ----------------------------------------------------------------------------
// cfr_front
// Accepts items, tracks chunk parsing and idle time, and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_front #(
    parameter int P_MAX_CHUNK = cfr_pkg::C_MAX_CHUNK
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_chunk_start,
    input  wire logic [9:0]    i_chunk_length,
    input  wire logic [15:0]   i_timeout_ms,
    input  wire logic          i_q_full,
    output logic               o_push,
    output cfr_pkg::t_cmd      o_cmd
);

    localparam int PW = $clog2(P_MAX_CHUNK + 1);

    localparam logic [1:0] ROLE_IGNORE = 2'd0;
    localparam logic [1:0] ROLE_MAYBE  = 2'd1;
    localparam logic [1:0] ROLE_HEADER = 2'd2;
    localparam logic [1:0] ROLE_DATA   = 2'd3;

    logic [16:0]   r_idle, n_idle;
    logic [PW-1:0] r_pos, n_pos;
    logic [1:0]    r_role, n_role;
    logic [31:0]   r_acc, n_acc;
    cfr_pkg::t_cmd cmd;
    logic          cmd_v;
    logic          accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && cmd_v;
    assign o_cmd   = cmd;

    always_comb begin
        n_idle = r_idle;
        n_pos  = r_pos;
        n_role = r_role;
        n_acc  = r_acc;
        cmd    = '0;
        cmd_v  = 1'b0;
        if (!i_mode) begin
            if (r_idle != cfr_pkg::C_IDLE_MAX) begin
                n_idle = r_idle + 17'd1;
            end
        end else if (i_chunk_start) begin
            n_pos  = '0;
            n_role = ROLE_IGNORE;
            // An empty chunk clears the position but leaves the idle count alone.
            if (i_chunk_length != 10'd0) begin
                n_idle         = '0;
                n_pos          = PW'(1);
                cmd.op         = cfr_pkg::OP_START;
                cmd.tmo        = (r_idle > {1'b0, i_timeout_ms});
                cmd.data_byte  = i_data_byte;
                if (i_chunk_length >= cfr_pkg::C_HDR_MIN && i_data_byte == cfr_pkg::C_SYNC0) begin
                    n_role  = ROLE_MAYBE;
                    cmd.act = 1'b0;
                end else begin
                    // The back drops data bytes when no frame is open, so the
                    // stray case can share the data role.
                    n_role  = ROLE_DATA;
                    cmd.act = 1'b1;
                end
                cmd_v = cmd.tmo || cmd.act;
            end
        end else begin
            n_idle = '0;
            if (r_pos < PW'(P_MAX_CHUNK)) begin
                n_pos = r_pos + PW'(1);
            end
            unique case (r_role)
                ROLE_MAYBE: begin
                    cmd.data_byte = i_data_byte;
                    cmd_v         = 1'b1;
                    if (i_data_byte == cfr_pkg::C_SYNC1) begin
                        n_role = ROLE_HEADER;
                        n_acc  = '0;
                        cmd.op = cfr_pkg::OP_DROP;
                    end else begin
                        n_role = ROLE_DATA;
                        cmd.op = cfr_pkg::OP_PAIR;
                    end
                end
                ROLE_HEADER: begin
                    if (r_pos >= PW'(2) && r_pos <= PW'(5)) begin
                        n_acc = {r_acc[23:0], i_data_byte};
                    end
                    if (r_pos == PW'(5)) begin
                        n_role     = ROLE_IGNORE;
                        cmd.op     = cfr_pkg::OP_JUDGE;
                        cmd.length = {r_acc[23:0], i_data_byte};
                        cmd_v      = 1'b1;
                    end
                end
                ROLE_DATA: begin
                    cmd.op        = cfr_pkg::OP_DATA;
                    cmd.data_byte = i_data_byte;
                    cmd_v         = 1'b1;
                end
                ROLE_IGNORE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
            r_pos  <= '0;
            r_role <= ROLE_IGNORE;
            r_acc  <= '0;
        end else if (accept) begin
            r_idle <= n_idle;
            r_pos  <= n_pos;
            r_role <= n_role;
            r_acc  <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ===== src/cfr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// cfr_cmd_fifo
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cfr_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output cfr_pkg::t_cmd      o_data
);

    localparam int DEPTH = cfr_pkg::C_CMDQ_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cfr_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/cfr_back.sv =====
// ----------------------------------------------------------------------------
// cfr_back
// Executes commands against the open frame and drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_max_frame_length,
    input  wire logic          i_q_valid,
    input  wire cfr_pkg::t_cmd i_q_data,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output cfr_pkg::t_result   o_result
);

    logic             r_rcv, n_rcv;
    logic [15:0]      r_expected, n_expected;
    logic [15:0]      r_count, n_count;
    logic             r_out_v, n_out_v;
    logic             r_pend_v, n_pend_v;
    cfr_pkg::t_result r_out, n_out;
    cfr_pkg::t_result r_pend, n_pend;

    cfr_pkg::t_result res0, res1;
    logic             has0, has1;
    logic             rcv_t, done0, done1;
    logic [15:0]      count1;
    logic [31:0]      limit;

    function automatic cfr_pkg::t_result make_res(input logic [2:0] kind,
                                                  input logic [14:0] off,
                                                  input logic [7:0] pay,
                                                  input logic done,
                                                  input logic [31:0] decl);
        cfr_pkg::t_result r;
        r.kind            = kind;
        r.offset          = off;
        r.payload         = pay;
        r.frame_done      = done;
        r.declared_length = decl;
        r.run_last        = 1'b0;
        return r;
    endfunction

    // A new command is taken only when the output register can absorb it.
    assign o_pop    = i_q_valid && !r_pend_v && (!r_out_v || i_ready);
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    assign limit  = ({16'd0, i_max_frame_length} > cfr_pkg::C_MAX_FRAME) ?
                    cfr_pkg::C_MAX_FRAME : {16'd0, i_max_frame_length};
    assign count1 = r_count + 16'd1;
    assign done0  = (count1 == r_expected);
    assign done1  = ((r_count + 16'd2) == r_expected);

    always_comb begin
        n_rcv      = r_rcv;
        n_expected = r_expected;
        n_count    = r_count;
        res0       = '0;
        res1       = '0;
        has0       = 1'b0;
        has1       = 1'b0;
        rcv_t      = r_rcv;
        unique case (i_q_data.op)
            cfr_pkg::OP_START: begin
                if (i_q_data.tmo && r_rcv) begin
                    has0       = 1'b1;
                    res0       = make_res(cfr_pkg::KIND_TIMEOUT, '0, '0, 1'b0, '0);
                    rcv_t      = 1'b0;
                    n_rcv      = 1'b0;
                    n_expected = '0;
                    n_count    = '0;
                end
                if (i_q_data.act) begin
                    if (rcv_t) begin
                        has0    = 1'b1;
                        res0    = make_res(cfr_pkg::KIND_DATA, r_count[14:0],
                                           i_q_data.data_byte, done0, '0);
                        n_count = count1;
                        if (done0) begin
                            n_rcv      = 1'b0;
                            n_expected = '0;
                            n_count    = '0;
                        end
                    end else if (has0) begin
                        has1 = 1'b1;
                        res1 = make_res(cfr_pkg::KIND_STRAY, '0, '0, 1'b0, '0);
                    end else begin
                        has0 = 1'b1;
                        res0 = make_res(cfr_pkg::KIND_STRAY, '0, '0, 1'b0, '0);
                    end
                end
            end
            cfr_pkg::OP_DATA: begin
                if (r_rcv) begin
                    has0    = 1'b1;
                    res0    = make_res(cfr_pkg::KIND_DATA, r_count[14:0],
                                       i_q_data.data_byte, done0, '0);
                    n_count = count1;
                    if (done0) begin
                        n_rcv      = 1'b0;
                        n_expected = '0;
                        n_count    = '0;
                    end
                end
            end
            cfr_pkg::OP_PAIR: begin
                // The held first byte of a failed header is always the sync byte.
                if (r_rcv) begin
                    has0    = 1'b1;
                    res0    = make_res(cfr_pkg::KIND_DATA, r_count[14:0],
                                       cfr_pkg::C_SYNC0, done0, '0);
                    n_count = count1;
                    if (done0) begin
                        n_rcv      = 1'b0;
                        n_expected = '0;
                        n_count    = '0;
                    end else begin
                        has1    = 1'b1;
                        res1    = make_res(cfr_pkg::KIND_DATA, count1[14:0],
                                           i_q_data.data_byte, done1, '0);
                        n_count = r_count + 16'd2;
                        if (done1) begin
                            n_rcv      = 1'b0;
                            n_expected = '0;
                            n_count    = '0;
                        end
                    end
                end else begin
                    has0 = 1'b1;
                    res0 = make_res(cfr_pkg::KIND_STRAY, '0, '0, 1'b0, '0);
                end
            end
            cfr_pkg::OP_DROP: begin
                n_rcv      = 1'b0;
                n_expected = '0;
                n_count    = '0;
            end
            cfr_pkg::OP_JUDGE: begin
                has0 = 1'b1;
                if (i_q_data.length > limit) begin
                    res0       = make_res(cfr_pkg::KIND_TOO_BIG, '0, '0, 1'b0,
                                          i_q_data.length);
                    n_rcv      = 1'b0;
                    n_expected = '0;
                    n_count    = '0;
                end else if (i_q_data.length == 32'd0) begin
                    res0       = make_res(cfr_pkg::KIND_ZERO_LEN, '0, '0, 1'b0,
                                          i_q_data.length);
                    n_rcv      = 1'b0;
                    n_expected = '0;
                    n_count    = '0;
                end else begin
                    res0       = make_res(cfr_pkg::KIND_HEADER, '0, '0, 1'b0,
                                          i_q_data.length);
                    n_rcv      = 1'b1;
                    n_expected = i_q_data.length[15:0];
                    n_count    = '0;
                end
            end
            default: begin
            end
        endcase
        res0.run_last = !has1;
        res1.run_last = 1'b1;
    end

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        if (r_out_v && i_ready) begin
            if (r_pend_v) begin
                n_out    = r_pend;
                n_out_v  = 1'b1;
                n_pend_v = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end
        if (o_pop && has0) begin
            n_out    = res0;
            n_out_v  = 1'b1;
            n_pend   = res1;
            n_pend_v = has1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcv      <= 1'b0;
            r_expected <= '0;
            r_count    <= '0;
            r_out_v    <= 1'b0;
            r_pend_v   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rcv      <= n_rcv;
                r_expected <= n_expected;
                r_count    <= n_count;
            end
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

`ifndef NO_ASSERTIONS
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_out_v)
        else $error("second result pending without a result on the output");

    a_open_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcv |-> (r_count < r_expected))
        else $error("open frame has no bytes left to receive");

    a_closed_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rcv |-> (r_count == 16'd0 && r_expected == 16'd0))
        else $error("closed frame left counters behind");

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && has0 && res0.frame_done && !has1) |=> !r_rcv)
        else $error("completed frame still open");
`endif

endmodule

`default_nettype wire
